### sv/spte_pkg.sv
// Shared types and field constants for the sprite entry tile expander.
package spte_pkg;

    localparam int unsigned WORD_W   = 16;
    localparam int unsigned TILE_W   = 13;
    localparam int unsigned POS_W    = 9;
    localparam int unsigned SCR_W    = 10;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned PAL_W    = 4;

    // attribute word bit positions
    localparam int unsigned ATTR_DISABLE = 15;
    localparam int unsigned ATTR_FLIPY   = 14;
    localparam int unsigned ATTR_FLIPX   = 13;
    localparam int unsigned ATTR_PRIO    = 11;
    localparam int unsigned ATTR_W_LO    = 7;
    localparam int unsigned ATTR_H_LO    = 4;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture a new entry and clear the tile counters
        logic emit;   // write the current tile to the output register, step on
    } spte_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic entry_disabled;  // disable bit of the item on the input port
        logic at_last;         // counters sit on the final tile
        logic out_free;        // output register can take a tile this cycle
    } spte_sts_t;

endpackage

### sv/spte_ctrl.sv
// Controller state machine for the sprite entry tile expander.
module spte_ctrl
    import spte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  spte_sts_t sts,
    output spte_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !sts.entry_disabled)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.at_last)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### sv/spte_dp.sv
// Datapath for the sprite entry tile expander: entry fields, tile counters, output register.
module spte_dp
    import spte_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [WORD_W-1:0]       attr_word,
    input  logic [WORD_W-1:0]       tile_word,
    input  logic [WORD_W-1:0]       x_word,
    input  logic [WORD_W-1:0]       y_word,
    input  spte_cmd_t               cmd,
    output spte_sts_t               sts,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [TILE_W-1:0]       tile_code,
    output logic [PAL_W-1:0]        palette,
    output logic                    mirror_x,
    output logic                    mirror_y,
    output logic signed [SCR_W-1:0] screen_x,
    output logic signed [SCR_W-1:0] screen_y,
    output logic                    behind_foreground,
    output logic                    last_tile
);

    // entry fields
    logic [CNT_W-1:0]  wm1_reg, hm1_reg;
    logic [PAL_W-1:0]  pal_reg;
    logic              fx_reg, fy_reg, pri_reg;
    logic [POS_W-1:0]  px_reg, py_reg;
    // running counters
    logic [TILE_W-1:0] tile_reg;
    logic [CNT_W-1:0]  cx_reg, cy_reg;
    // output register
    logic              out_valid_reg;
    logic [TILE_W-1:0] tile_code_reg;
    logic [PAL_W-1:0]  pal_out_reg;
    logic              fx_out_reg, fy_out_reg, pri_out_reg, last_out_reg;
    logic [SCR_W-1:0]  sx_reg, sy_reg;

    logic [CNT_W-1:0]  ox, oy;
    logic [SCR_W-1:0]  sx_next, sy_next;
    logic              col_end, row_end;

    assign col_end = (cx_reg == wm1_reg);
    assign row_end = (cy_reg == hm1_reg);

    assign ox = fx_reg ? (wm1_reg - cx_reg) : cx_reg;
    assign oy = fy_reg ? (hm1_reg - cy_reg) : cy_reg;

    // sign-extended 9-bit position plus 16 per tile, wraps in 10 bits
    assign sx_next = {px_reg[POS_W-1], px_reg} + {{(SCR_W-CNT_W-4){1'b0}}, ox, 4'b0000};
    assign sy_next = {py_reg[POS_W-1], py_reg} + {{(SCR_W-CNT_W-4){1'b0}}, oy, 4'b0000};

    assign sts.entry_disabled = attr_word[ATTR_DISABLE];
    assign sts.at_last        = col_end && row_end;
    assign sts.out_free       = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            wm1_reg  <= attr_word[ATTR_W_LO +: CNT_W];
            hm1_reg  <= attr_word[ATTR_H_LO +: CNT_W];
            pal_reg  <= attr_word[PAL_W-1:0];
            fx_reg   <= attr_word[ATTR_FLIPX];
            fy_reg   <= attr_word[ATTR_FLIPY];
            pri_reg  <= attr_word[ATTR_PRIO];
            px_reg   <= x_word[POS_W-1:0];
            py_reg   <= y_word[POS_W-1:0];
            tile_reg <= tile_word[TILE_W-1:0];
            cx_reg   <= '0;
            cy_reg   <= '0;
        end
        else if (cmd.emit)
        begin
            tile_reg <= tile_reg + 1'b1;
            if (row_end)
            begin
                cy_reg <= '0;
                cx_reg <= cx_reg + 1'b1;
            end
            else
                cy_reg <= cy_reg + 1'b1;
        end

        if (cmd.emit)
        begin
            tile_code_reg <= tile_reg;
            pal_out_reg   <= pal_reg;
            fx_out_reg    <= fx_reg;
            fy_out_reg    <= fy_reg;
            pri_out_reg   <= pri_reg;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            last_out_reg  <= col_end && row_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid         = out_valid_reg;
    assign tile_code         = tile_code_reg;
    assign palette           = pal_out_reg;
    assign mirror_x          = fx_out_reg;
    assign mirror_y          = fy_out_reg;
    assign screen_x          = sx_reg;
    assign screen_y          = sy_reg;
    assign behind_foreground = pri_out_reg;
    assign last_tile         = last_out_reg;

endmodule

### sv/sprite_entry_tile_expander_core.sv
// Top level of the sprite entry tile expander: controller plus datapath.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | input     | in_valid / in_ready   | attr_word, tile_word, x_word, y_word
//  out     | output    | out_valid / out_ready | tile_code, palette, mirror_x, mirror_y,
//          |           |                       | screen_x, screen_y, behind_foreground,
//          |           |                       | last_tile
//
// An enabled entry of W x H tiles gives W*H tile items, one per cycle when the
// output is not stalled. The accepting cycle loads the entry, then in_ready
// stays low while its W*H tiles (1 to 64) go out and the tile counter steps
// once per emitted tile.
// A disabled entry is taken while the controller stays idle and gives no item.
// The single output register lets a new entry be taken while the final tile of
// the previous one still waits; output stalls simply hold the tile counters.
// Reset (rst_n, asynchronous, active low) clears the controller and output valid.
module sprite_entry_tile_expander_core
    import spte_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [WORD_W-1:0]       attr_word,
    input  logic [WORD_W-1:0]       tile_word,
    input  logic [WORD_W-1:0]       x_word,
    input  logic [WORD_W-1:0]       y_word,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [TILE_W-1:0]       tile_code,
    output logic [PAL_W-1:0]        palette,
    output logic                    mirror_x,
    output logic                    mirror_y,
    output logic signed [SCR_W-1:0] screen_x,
    output logic signed [SCR_W-1:0] screen_y,
    output logic                    behind_foreground,
    output logic                    last_tile
);

    spte_cmd_t cmd;
    spte_sts_t sts;

    // sequencer: idle takes entries, run emits one tile per free output slot
    spte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // entry fields, column/row counters, position arithmetic and output register
    spte_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .attr_word         (attr_word),
        .tile_word         (tile_word),
        .x_word            (x_word),
        .y_word            (y_word),
        .cmd               (cmd),
        .sts               (sts),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .tile_code         (tile_code),
        .palette           (palette),
        .mirror_x          (mirror_x),
        .mirror_y          (mirror_y),
        .screen_x          (screen_x),
        .screen_y          (screen_y),
        .behind_foreground (behind_foreground),
        .last_tile         (last_tile)
    );

endmodule

### sv/spte_chk.sv
// Port-level checker for the sprite entry tile expander, with its bind.
module spte_chk
    import spte_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic [WORD_W-1:0]       attr_word,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [TILE_W-1:0]       tile_code,
    input logic signed [SCR_W-1:0] screen_x,
    input logic                    last_tile
);

    // stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tile_code) && $stable(screen_x))
        else $error("stalled output item changed");

    // an enabled entry blocks the input while its tiles go out
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !attr_word[ATTR_DISABLE] |=> !in_ready)
        else $error("input taken again straight after an enabled entry");

    // a tile that is not the last means the entry is still being expanded
    a_mid_sprite_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_tile |-> !in_ready)
        else $error("input ready in the middle of a sprite");

    // when an entry is taken, only the previous sprite's final tile can be waiting
    a_clean_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !attr_word[ATTR_DISABLE] |=> !out_valid || last_tile)
        else $error("stale tile in output register at sprite start");

endmodule

bind sprite_entry_tile_expander_core spte_chk u_spte_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .attr_word (attr_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tile_code (tile_code),
    .screen_x  (screen_x),
    .last_tile (last_tile)
);

### dv/tb.sv
// Self-checking testbench for sprite_entry_tile_expander_core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spte_pkg::*;

    localparam int MAX_WAIT      = 17;   // longest idle either side draws per item
    localparam int SETTLE_CYCLES = 80;   // longer than the biggest sprite (64 tiles)
    localparam int LONG_HOLD     = 400;  // receiver hold-off for the backpressure test
    localparam int MAX_PRINTS    = 60;

    // one expected tile draw command
    typedef struct packed {
        logic [TILE_W-1:0]       code;
        logic [PAL_W-1:0]        pal;
        logic                    mir_x;
        logic                    mir_y;
        logic signed [SCR_W-1:0] pos_x;
        logic signed [SCR_W-1:0] pos_y;
        logic                    behind;
        logic                    is_last;
    } tile_cmd_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic [WORD_W-1:0]       attr_word = '0;
    logic [WORD_W-1:0]       tile_word = '0;
    logic [WORD_W-1:0]       x_word    = '0;
    logic [WORD_W-1:0]       y_word    = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [TILE_W-1:0]       tile_code;
    logic [PAL_W-1:0]        palette;
    logic                    mirror_x;
    logic                    mirror_y;
    logic signed [SCR_W-1:0] screen_x;
    logic signed [SCR_W-1:0] screen_y;
    logic                    behind_foreground;
    logic                    last_tile;

    tile_cmd_t expected_tiles[$];
    int        error_count     = 0;
    bit        sender_steady   = 1'b0;
    bit        receiver_steady = 1'b0;
    int        hold_request    = 0;

    sprite_entry_tile_expander_core u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .attr_word         (attr_word),
        .tile_word         (tile_word),
        .x_word            (x_word),
        .y_word            (y_word),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .tile_code         (tile_code),
        .palette           (palette),
        .mirror_x          (mirror_x),
        .mirror_y          (mirror_y),
        .screen_x          (screen_x),
        .screen_y          (screen_y),
        .behind_foreground (behind_foreground),
        .last_tile         (last_tile)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction: expand one entry into its tile commands, column outer,
    // row inner, tile number stepping by one and wrapping at 13 bits.
    // ------------------------------------------------------------------
    function automatic void expand_entry(input logic [WORD_W-1:0] attr,
                                         input logic [WORD_W-1:0] tile_w,
                                         input logic [WORD_W-1:0] xw,
                                         input logic [WORD_W-1:0] yw);
        int                      cols_m1;
        int                      rows_m1;
        int                      ox;
        int                      oy;
        logic [TILE_W-1:0]       code;
        logic signed [SCR_W-1:0] base_x;
        logic signed [SCR_W-1:0] base_y;
        tile_cmd_t               cmd;
        if (attr[ATTR_DISABLE])
            return;
        cols_m1 = int'(attr[ATTR_W_LO +: CNT_W]);
        rows_m1 = int'(attr[ATTR_H_LO +: CNT_W]);
        code    = tile_w[TILE_W-1:0];
        // 9-bit two's complement position widened to the 10-bit screen field
        base_x  = {xw[POS_W-1], xw[POS_W-1:0]};
        base_y  = {yw[POS_W-1], yw[POS_W-1:0]};
        for (int c = 0; c <= cols_m1; c++)
        begin
            for (int r = 0; r <= rows_m1; r++)
            begin
                ox          = attr[ATTR_FLIPX] ? cols_m1 - c : c;
                oy          = attr[ATTR_FLIPY] ? rows_m1 - r : r;
                cmd.code    = code;
                cmd.pal     = attr[PAL_W-1:0];
                cmd.mir_x   = attr[ATTR_FLIPX];
                cmd.mir_y   = attr[ATTR_FLIPY];
                cmd.pos_x   = SCR_W'(int'(base_x) + 16 * ox);
                cmd.pos_y   = SCR_W'(int'(base_y) + 16 * oy);
                cmd.behind  = attr[ATTR_PRIO];
                cmd.is_last = (c == cols_m1) && (r == rows_m1);
                expected_tiles.push_back(cmd);
                code = code + 1'b1;
            end
        end
    endfunction

    function automatic logic [WORD_W-1:0] make_attr(input bit disabled, input bit flip_y,
                                                    input bit flip_x, input bit prio,
                                                    input int cols, input int rows,
                                                    input int colour);
        logic [WORD_W-1:0] a;
        a                       = '0;
        a[ATTR_DISABLE]         = disabled;
        a[ATTR_FLIPY]           = flip_y;
        a[ATTR_FLIPX]           = flip_x;
        a[ATTR_PRIO]            = prio;
        a[ATTR_W_LO +: CNT_W]   = CNT_W'(cols - 1);
        a[ATTR_H_LO +: CNT_W]   = CNT_W'(rows - 1);
        a[PAL_W-1:0]            = PAL_W'(colour);
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("ERROR @%0t: %s got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_tile();
        tile_cmd_t want;
        if (expected_tiles.size() == 0)
        begin
            report_mismatch("tile item with nothing expected, tile_code", tile_code, -1);
            return;
        end
        want = expected_tiles.pop_front();
        if (tile_code !== want.code)
            report_mismatch("tile_code", tile_code, want.code);
        if (palette !== want.pal)
            report_mismatch("palette", palette, want.pal);
        if (mirror_x !== want.mir_x)
            report_mismatch("mirror_x", mirror_x, want.mir_x);
        if (mirror_y !== want.mir_y)
            report_mismatch("mirror_y", mirror_y, want.mir_y);
        if (screen_x !== want.pos_x)
            report_mismatch("screen_x", screen_x, want.pos_x);
        if (screen_y !== want.pos_y)
            report_mismatch("screen_y", screen_y, want.pos_y);
        if (behind_foreground !== want.behind)
            report_mismatch("behind_foreground", behind_foreground, want.behind);
        if (last_tile !== want.is_last)
            report_mismatch("last_tile", last_tile, want.is_last);
    endtask

    // Values read here are the ones from just before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_tile();
    end

    // Receiver: random stall before each item, an optional long hold-off.
    initial
    begin : tile_sink
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                stall        = hold_request;
                hold_request = 0;
            end
            else if (receiver_steady)
                stall = 0;
            else
                stall = $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Sender: called and returns on a rising edge. Valid is only lowered
    // when a gap is drawn, so back-to-back items keep it high.
    // ------------------------------------------------------------------
    task automatic send_entry(input logic [WORD_W-1:0] attr, input logic [WORD_W-1:0] tile_w,
                              input logic [WORD_W-1:0] xw, input logic [WORD_W-1:0] yw);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        attr_word <= attr;
        tile_word <= tile_w;
        x_word    <= xw;
        y_word    <= yw;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expand_entry(attr, tile_w, xw, yw);
    endtask

    task automatic send_random_entry();
        logic [WORD_W-1:0] attr;
        attr = WORD_W'($urandom);
        // roughly one in twelve entries left disabled
        if ($urandom_range(0, 5) != 0)
            attr[ATTR_DISABLE] = 1'b0;
        send_entry(attr, WORD_W'($urandom), WORD_W'($urandom), WORD_W'($urandom));
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_tiles.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_entries();
        // smallest sprite, all fields zero
        send_entry(make_attr(0, 0, 0, 0, 1, 1, 0), 16'h0000, 16'h0000, 16'h0000);
        // disabled entries: everything set, and disable bit alone
        send_entry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_entry(16'h8000, 16'h0000, 16'h0000, 16'h0000);
        // biggest sprite, both flips, priority, top colour, tile wrap, highest positions
        send_entry(make_attr(0, 1, 1, 1, 8, 8, 15), 16'hFFFF, 16'hFEFF, 16'hFEFF);
        // biggest sprite at the most negative corner, tile number ends at the 13-bit maximum
        send_entry(make_attr(0, 0, 0, 0, 8, 8, 0), 16'h1FC0, 16'h0100, 16'h0100);
        // horizontal flip only, then vertical flip only, uneven shapes
        send_entry(make_attr(0, 0, 1, 0, 3, 5, 5), 16'h0123, 16'h0040, 16'h0080);
        send_entry(make_attr(0, 1, 0, 0, 5, 3, 10), 16'h0ABC, 16'h01F0, 16'h0010);
        // priority with the unused attribute bits set
        send_entry(make_attr(0, 0, 0, 1, 2, 7, 3) | 16'h1400, 16'hE001, 16'h0033, 16'h01C0);
        // one row wide strip at x = -1, one column tall strip flipped
        send_entry(make_attr(0, 0, 0, 0, 8, 1, 7), 16'h1FFE, 16'h01FF, 16'h00FF);
        send_entry(make_attr(0, 1, 1, 0, 1, 8, 9), 16'h1000, 16'h00FF, 16'h01FF);
        // ignored upper bits of the position words, then a disabled entry with every other field set
        send_entry(make_attr(0, 0, 1, 1, 8, 1, 12), 16'h5555, 16'hFE00, 16'hAA80);
        send_entry(make_attr(1, 1, 1, 1, 8, 8, 15), 16'h1FFF, 16'h00FF, 16'h00FF);
    endtask

    task automatic test_random_entries();
        for (int i = 0; i < 90; i++)
        begin
            send_random_entry();
            if (i % 30 == 29)
                pause_until_drained();
        end
    endtask

    // no idling on either side
    task automatic test_back_to_back();
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        for (int i = 0; i < 20; i++)
            send_random_entry();
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // receiver holds off for a long stretch while entries keep coming
    task automatic test_output_backpressure();
        hold_request  = LONG_HOLD;
        sender_steady = 1'b1;
        for (int i = 0; i < 12; i++)
            send_random_entry();
        sender_steady = 1'b0;
    endtask

    task automatic test_pause_for_drain();
        for (int i = 0; i < 6; i++)
        begin
            send_random_entry();
            if (i == 2)
                pause_until_drained();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_entries();
        test_random_entries();
        test_back_to_back();
        test_output_backpressure();
        test_pause_for_drain();
        pause_until_drained();
        // catch any stray tile after the last expected one
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_tiles.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
